// File: rtl/swp_pkg.sv
// Shared constants and types of the sliding-window 99th-percentile tracker.
`default_nettype none

package swp_pkg;

  // Number of samples held in the window.
  localparam int WINDOW = 128;

  // Slot index width and fill count width (the count can hold WINDOW itself).
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  // Field widths of the stream words.
  localparam int SAMPLE_W = 32;
  localparam int FILL_W   = 8;
  localparam int OUT_W    = SAMPLE_W + FILL_W;

  // floor(n / 100) is taken as (n * RANK_RECIP) >> RANK_SHIFT, exact for n below 43690.
  localparam int RANK_RECIP_W = 13;
  localparam logic [RANK_RECIP_W-1:0] RANK_RECIP = 13'd5243;
  localparam int RANK_SHIFT = 19;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AW-1:0]       slot_t;
  typedef logic [CW-1:0]       count_t;

endpackage : swp_pkg

`default_nettype wire

// File: rtl/swp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module swp_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : swp_ram

`default_nettype wire

// File: rtl/sliding_window_p99_tracker_core.sv
// Top level of the sliding-window 99th-percentile tracker with its pass sequencer.
//
// Use: each word on the in_ channel is one latency sample (unsigned fixed point,
// 10 fractional bits). The block keeps the last WINDOW samples in a ring and, beside
// it, the same samples in ascending order. For every sample it returns one word on
// the out_ channel: the window element of rank ceil(0.99 * n) - 1 and the fill n.
// Per sample the sequencer captures the evicted sample from the ring, then, once the
// window is full, runs a removal pass over the sorted store (WINDOW reads, one per
// cycle, closing the gap left by the evicted value), then an insertion pass that walks
// down from the top and shifts larger values up one slot, then reads the result.
// Both passes go through the single read port of the sorted store and one shared
// comparator, so they run one after the other. in_tready is high only while the
// sequencer is idle, so a sample is taken only once the last one has been worked
// through. The result sits in an output register, so a new sample is taken while
// the previous result waits; a stalled receiver holds the sequencer at its last
// step until the register frees.
// Reset (rst_n low, synchronous) empties the window; the stores need no clearing.
`default_nettype none

module sliding_window_p99_tracker_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [swp_pkg::SAMPLE_W-1:0] in_tdata,  // [31:0] latency_sample
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [swp_pkg::OUT_W-1:0]  out_tdata  // [31:0] p99_latency, [39:32] window_fill
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAPTURE,
    ST_REMOVE,
    ST_INSERT,
    ST_INS_LAST,
    ST_SEL_RD,
    ST_OUT
  } state_t;

  state_t           state_r, state_nxt;
  swp_pkg::slot_t   head_r, head_nxt;
  swp_pkg::count_t  fill_r, fill_nxt;
  swp_pkg::count_t  ins_cnt_r, ins_cnt_nxt;
  swp_pkg::sample_t sample_r, sample_nxt;
  swp_pkg::sample_t old_r, old_nxt;
  swp_pkg::slot_t   iss_idx_r, iss_idx_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             ret_vld_r, ret_vld_nxt;
  swp_pkg::slot_t   ret_idx_r, ret_idx_nxt;
  logic             found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  swp_pkg::sample_t out_p99_r, out_p99_nxt;
  logic [swp_pkg::FILL_W-1:0] out_fill_r, out_fill_nxt;

  // Ring store ports.
  logic             ring_we, ring_re;
  swp_pkg::sample_t ring_rdata;

  // Sorted store ports.
  logic             srt_we, srt_re;
  swp_pkg::slot_t   srt_waddr, srt_raddr;
  swp_pkg::sample_t srt_wdata, srt_rdata;

  // Shared comparator and rank index.
  swp_pkg::sample_t cmp_key;
  logic             cmp_eq, cmp_gt;
  logic [swp_pkg::CW+swp_pkg::RANK_RECIP_W-1:0] rank_prod;
  swp_pkg::count_t  div100;
  swp_pkg::count_t  rank_cnt;
  swp_pkg::slot_t   sel_idx;
  logic             in_acc, window_full, ins_empty;

  localparam swp_pkg::slot_t LAST_SLOT = swp_pkg::AW'(swp_pkg::WINDOW - 1);

  swp_ram #(.DEPTH(swp_pkg::WINDOW), .WIDTH(swp_pkg::SAMPLE_W)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head_r),
    .wdata (sample_r),
    .re    (ring_re),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  swp_ram #(.DEPTH(swp_pkg::WINDOW), .WIDTH(swp_pkg::SAMPLE_W)) u_sorted (
    .clk   (clk),
    .we    (srt_we),
    .waddr (srt_waddr),
    .wdata (srt_wdata),
    .re    (srt_re),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_fill_r, out_p99_r};

  // The removal pass looks for the evicted value, the insertion pass compares with the new one.
  assign cmp_key = (state_r == ST_REMOVE) ? old_r : sample_r;
  assign cmp_eq  = (srt_rdata == cmp_key);
  assign cmp_gt  = (srt_rdata > cmp_key);

  // Rank index n - floor(n / 100) - 1, which equals ceil(0.99 * n) - 1 for n of at least one.
  assign rank_prod = swp_pkg::CW'(fill_r) * swp_pkg::RANK_RECIP;
  assign div100    = swp_pkg::CW'(rank_prod >> swp_pkg::RANK_SHIFT);
  assign rank_cnt  = fill_r - div100 - swp_pkg::CW'(1);
  assign sel_idx   = rank_cnt[swp_pkg::AW-1:0];

  assign window_full = (fill_r == swp_pkg::CW'(swp_pkg::WINDOW));
  assign ins_empty   = (ins_cnt_r == '0);

  // Sequencer next-state and store control.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    ins_cnt_nxt   = ins_cnt_r;
    sample_nxt    = sample_r;
    old_nxt       = old_r;
    iss_idx_nxt   = iss_idx_r;
    iss_done_nxt  = iss_done_r;
    ret_vld_nxt   = 1'b0;
    ret_idx_nxt   = ret_idx_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_p99_nxt   = out_p99_r;
    out_fill_nxt  = out_fill_r;
    ring_we       = 1'b0;
    ring_re       = 1'b0;
    srt_we        = 1'b0;
    srt_re        = 1'b0;
    srt_waddr     = ret_idx_r;
    srt_raddr     = iss_idx_r;
    srt_wdata     = srt_rdata;

    // The output register frees once its word is taken.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // The ring slot under the head is read only once it holds a sample.
      ST_IDLE: begin
        if (in_acc) begin
          sample_nxt = in_tdata;
          ring_re    = window_full;
          state_nxt  = ST_CAPTURE;
        end
      end

      // Keep the evicted sample, store the new one and advance the ring.
      ST_CAPTURE: begin
        old_nxt      = ring_rdata;
        ring_we      = 1'b1;
        head_nxt     = (head_r == LAST_SLOT) ? '0 : head_r + swp_pkg::AW'(1);
        iss_done_nxt = 1'b0;
        found_nxt    = 1'b0;
        if (window_full) begin
          ins_cnt_nxt = swp_pkg::CW'(swp_pkg::WINDOW - 1);
          iss_idx_nxt = '0;
          state_nxt   = ST_REMOVE;
        end else begin
          fill_nxt    = fill_r + swp_pkg::CW'(1);
          ins_cnt_nxt = fill_r;
          iss_idx_nxt = swp_pkg::AW'(fill_r - swp_pkg::CW'(1));
          state_nxt   = (fill_r == '0) ? ST_INS_LAST : ST_INSERT;
        end
      end

      // Ascending scan: drop the first copy of the evicted value, move the rest down.
      ST_REMOVE: begin
        if (!iss_done_r) begin
          srt_re      = 1'b1;
          ret_vld_nxt = 1'b1;
          ret_idx_nxt = iss_idx_r;
          if (iss_idx_r == LAST_SLOT) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_idx_nxt = iss_idx_r + swp_pkg::AW'(1);
          end
        end
        if (ret_vld_r) begin
          if (found_r) begin
            srt_we    = 1'b1;
            srt_waddr = ret_idx_r - swp_pkg::AW'(1);
            srt_wdata = srt_rdata;
          end else if (cmp_eq) begin
            found_nxt = 1'b1;
          end
          if (ret_idx_r == LAST_SLOT) begin
            ret_vld_nxt  = 1'b0;
            iss_done_nxt = 1'b0;
            iss_idx_nxt  = swp_pkg::AW'(ins_cnt_r - swp_pkg::CW'(1));
            state_nxt    = ins_empty ? ST_INS_LAST : ST_INSERT;
          end
        end
      end

      // Descending scan: shift larger values up one slot and drop the new one in its place.
      ST_INSERT: begin
        if (!iss_done_r) begin
          srt_re      = 1'b1;
          ret_vld_nxt = 1'b1;
          ret_idx_nxt = iss_idx_r;
          if (iss_idx_r == '0) begin
            iss_done_nxt = 1'b1;
          end else begin
            iss_idx_nxt = iss_idx_r - swp_pkg::AW'(1);
          end
        end
        if (ret_vld_r) begin
          srt_we    = 1'b1;
          srt_waddr = ret_idx_r + swp_pkg::AW'(1);
          if (cmp_gt) begin
            srt_wdata = srt_rdata;
            if (ret_idx_r == '0) begin
              ret_vld_nxt = 1'b0;
              state_nxt   = ST_INS_LAST;
            end
          end else begin
            srt_wdata   = sample_r;
            ret_vld_nxt = 1'b0;
            state_nxt   = ST_SEL_RD;
          end
        end
      end

      // The new sample is the smallest held, or the store was empty.
      ST_INS_LAST: begin
        srt_we    = 1'b1;
        srt_waddr = '0;
        srt_wdata = sample_r;
        state_nxt = ST_SEL_RD;
      end

      ST_SEL_RD: begin
        srt_re    = 1'b1;
        srt_raddr = sel_idx;
        state_nxt = ST_OUT;
      end

      // Hand the result to the output register as soon as it is free.
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_p99_nxt   = srt_rdata;
          out_fill_nxt  = swp_pkg::FILL_W'(fill_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      iss_done_r  <= 1'b0;
      ret_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      iss_done_r  <= iss_done_nxt;
      ret_vld_r   <= ret_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ins_cnt_r  <= ins_cnt_nxt;
    sample_r   <= sample_nxt;
    old_r      <= old_nxt;
    iss_idx_r  <= iss_idx_nxt;
    ret_idx_r  <= ret_idx_nxt;
    out_p99_r  <= out_p99_nxt;
    out_fill_r <= out_fill_nxt;
  end

endmodule : sliding_window_p99_tracker_core

`default_nettype wire

// File: rtl/swp_checker.sv
// Port-level checks of the tracker, bound to its top level.
`default_nettype none

module swp_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tvalid,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [swp_pkg::OUT_W-1:0]    out_tdata
);

  logic [swp_pkg::FILL_W-1:0] fill_seen;
  assign fill_seen = out_tdata[swp_pkg::OUT_W-1:swp_pkg::SAMPLE_W];

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // After a sample is taken the block is not ready in the cycle that follows.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample taken in back-to-back cycles");

  // A new result appears only at the end of a sample's work, never while idle.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a sample at work");

  // The reported fill is never zero and never above the window.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> fill_seen != '0 && fill_seen <= swp_pkg::FILL_W'(swp_pkg::WINDOW))
    else $error("window fill out of range");

endmodule : swp_checker

bind sliding_window_p99_tracker_core swp_checker u_swp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
